### rtl/fac_pkg.sv
// Shared types, sizes and codes for the fit allocator.
// No dependencies; used by fac_cell, fac_ctrl and the top level.
package fac_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int OWNER_BITS = 8;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W      = 16;
    localparam int SIZE_W     = 17;
    localparam logic [SIZE_W-1:0] CAP_MAX   = 17'h10000;
    localparam logic [SIZE_W-1:0] CAP_RESET = 17'd1024;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_ALLOC = 3'd0,
        STAT_REL   = 3'd1,
        STAT_OOM   = 3'd2,
        STAT_NOOWN = 3'd3,
        STAT_FULL  = 3'd4
    } status_t;

    // Register indexes
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_POLICY   = 1'b1;

    // Allocate/release kind
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic [OFF_W-1:0]      offset;
        logic [SIZE_W-1:0]     size;
        logic                  free;
        logic [OWNER_BITS-1:0] owner;
    } entry_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INIT,
        CMD_ALLOC,
        CMD_RELEASE,
        CMD_MERGE
    } cell_op_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t              op;
        logic [IDX_W-1:0]      pick;
        logic                  split;
        logic [SIZE_W-1:0]     req;
        logic [OWNER_BITS-1:0] owner;
        logic [SIZE_W-1:0]     cap;
        logic [CNT_W-1:0]      count;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_BOOT,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RELEASE,
        ST_MERGE,
        ST_DONE
    } state_t;

endpackage

### rtl/fac_cell.sv
// One table entry of the allocator; shifts with its neighbors on split/merge.
// Depends on fac_pkg.
module fac_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fac_pkg::IDX_W-1:0]     idx,
    input  fac_pkg::cell_cmd_t            cmd,
    input  fac_pkg::entry_t               left_entry,
    input  fac_pkg::entry_t               right_entry,
    output fac_pkg::entry_t               entry,
    output logic                          fit,
    output logic [fac_pkg::SIZE_W-1:0]    leftover,
    output logic                          match
);

    fac_pkg::entry_t entry_reg;
    fac_pkg::entry_t entry_next;
    logic            valid;
    logic [fac_pkg::CNT_W-1:0] my_pos;
    logic [fac_pkg::CNT_W-1:0] pick_pos;

    assign my_pos   = fac_pkg::CNT_W'(idx);
    assign pick_pos = fac_pkg::CNT_W'(cmd.pick);
    assign valid    = my_pos < cmd.count;

    // compare terms toward the controller
    assign entry    = entry_reg;
    assign fit      = valid && entry_reg.free && (entry_reg.size >= cmd.req);
    assign leftover = entry_reg.size - cmd.req;
    assign match    = valid && (entry_reg.owner == cmd.owner);

    // entry update
    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            fac_pkg::CMD_INIT:
            begin
                entry_next = '0;
                if (idx == '0)
                begin
                    entry_next.size = cmd.cap;
                    entry_next.free = 1'b1;
                end
            end
            fac_pkg::CMD_ALLOC:
            begin
                if (my_pos == pick_pos)
                begin
                    entry_next.free  = 1'b0;
                    entry_next.size  = cmd.req;
                    entry_next.owner = cmd.owner;
                end
                else if (cmd.split && (my_pos == pick_pos + 1'b1))
                begin
                    // remainder of the picked block
                    entry_next.offset = left_entry.offset + cmd.req[fac_pkg::OFF_W-1:0];
                    entry_next.size   = left_entry.size - cmd.req;
                    entry_next.free   = 1'b1;
                    entry_next.owner  = '0;
                end
                else if (cmd.split && (my_pos > pick_pos + 1'b1))
                begin
                    entry_next = left_entry;
                end
            end
            fac_pkg::CMD_RELEASE:
            begin
                if (match)
                begin
                    entry_next.free  = 1'b1;
                    entry_next.owner = '0;
                end
            end
            fac_pkg::CMD_MERGE:
            begin
                if (my_pos == pick_pos)
                    entry_next.size = entry_reg.size + right_entry.size;
                else if (my_pos > pick_pos)
                    entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

endmodule

### rtl/fac_ctrl.sv
// Request sequencer: config registers, fit scan, split/merge commands, result register.
// Depends on fac_pkg.
module fac_ctrl
(
    input  logic                              clk,
    input  logic                              rst_n,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fac_pkg::SIZE_W-1:0]        in_req,
    input  logic [fac_pkg::OWNER_BITS-1:0]    in_owner,
    input  logic                              in_action,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [2:0]                        out_status,
    output logic [fac_pkg::OFF_W-1:0]         out_offset,
    output logic [fac_pkg::SIZE_W-1:0]        out_size,
    // config
    input  logic                              cfg_wr,
    input  logic                              cfg_idx,
    input  logic [31:0]                       cfg_wdata,
    output logic [31:0]                       cfg_rdata,
    // cell row
    output fac_pkg::cell_cmd_t                cmd,
    input  fac_pkg::entry_t                   entries [fac_pkg::MAX_BLOCKS],
    input  logic [fac_pkg::MAX_BLOCKS-1:0]    fit_vec,
    input  logic [fac_pkg::SIZE_W-1:0]        left_vec [fac_pkg::MAX_BLOCKS],
    input  logic [fac_pkg::MAX_BLOCKS-1:0]    match_vec
);

    fac_pkg::state_t state_reg, state_next;
    logic [fac_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [fac_pkg::IDX_W-1:0]      pick_reg, pick_next;
    logic [fac_pkg::SIZE_W-1:0]     best_reg, best_next;
    logic                           found_reg, found_next;
    logic [fac_pkg::SIZE_W-1:0]     req_reg, req_next;
    logic [fac_pkg::OWNER_BITS-1:0] owner_reg, owner_next;
    logic [fac_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                           policy_reg, policy_next;
    logic [fac_pkg::SIZE_W-1:0]     cap_reg, cap_next;
    fac_pkg::status_t               res_status_reg, res_status_next;
    logic [fac_pkg::OFF_W-1:0]      res_off_reg, res_off_next;
    logic [fac_pkg::SIZE_W-1:0]     res_size_reg, res_size_next;
    logic                           m_valid_reg, m_valid_next;
    logic [2:0]                     m_status_reg, m_status_next;
    logic [fac_pkg::OFF_W-1:0]      m_off_reg, m_off_next;
    logic [fac_pkg::SIZE_W-1:0]     m_size_reg, m_size_next;

    logic [fac_pkg::IDX_W-1:0]      sel;
    logic                           scan_last;
    logic [fac_pkg::SIZE_W-1:0]     cap_wr;
    logic [fac_pkg::SIZE_W-1:0]     orig;
    logic                           split;
    logic                           table_full;
    logic                           pair_any;
    logic [fac_pkg::IDX_W-1:0]      pair_idx;
    logic                           out_free;
    logic                           accept;

    assign sel        = cnt_reg[fac_pkg::IDX_W-1:0];
    assign scan_last  = (cnt_reg + 1'b1) >= count_reg;
    assign cap_wr     = (cfg_wdata[fac_pkg::SIZE_W-1:0] > fac_pkg::CAP_MAX) ?
                        fac_pkg::CAP_MAX : cfg_wdata[fac_pkg::SIZE_W-1:0];
    assign orig       = entries[pick_reg].size;
    assign split      = orig > req_reg;
    assign table_full = count_reg == fac_pkg::CNT_W'(fac_pkg::MAX_BLOCKS);
    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = state_reg == fac_pkg::ST_IDLE;
    assign accept     = s_tvalid && s_tready;

    assign m_tvalid   = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_offset = m_off_reg;
    assign out_size   = m_size_reg;
    assign cfg_rdata  = (cfg_idx == fac_pkg::REG_POLICY) ? {31'd0, policy_reg} :
                        {{(32 - fac_pkg::SIZE_W){1'b0}}, cap_reg};

    // first adjacent pair of free blocks
    always_comb
    begin
        pair_any = 1'b0;
        pair_idx = '0;
        for (int i = fac_pkg::MAX_BLOCKS - 2; i >= 0; i--)
        begin
            if (entries[i].free && entries[i + 1].free &&
                (fac_pkg::CNT_W'(i + 1) < count_reg))
            begin
                pair_any = 1'b1;
                pair_idx = fac_pkg::IDX_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fac_pkg::ST_BOOT:
                state_next = fac_pkg::ST_IDLE;
            fac_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_action == fac_pkg::ACT_RELEASE)
                        state_next = fac_pkg::ST_RELEASE;
                    else if (in_req == '0)
                        state_next = fac_pkg::ST_DONE;
                    else
                        state_next = fac_pkg::ST_SCAN;
                end
            end
            fac_pkg::ST_SCAN:
            begin
                if (scan_last || (fit_vec[sel] && !policy_reg))
                    state_next = fac_pkg::ST_COMMIT;
            end
            fac_pkg::ST_COMMIT:
                state_next = fac_pkg::ST_DONE;
            fac_pkg::ST_RELEASE:
                state_next = (|match_vec) ? fac_pkg::ST_MERGE : fac_pkg::ST_DONE;
            fac_pkg::ST_MERGE:
            begin
                if (!pair_any)
                    state_next = fac_pkg::ST_DONE;
            end
            fac_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = fac_pkg::ST_IDLE;
            end
            default:
                state_next = fac_pkg::ST_IDLE;
        endcase
    end

    // cell commands
    always_comb
    begin
        cmd       = '0;
        cmd.op    = fac_pkg::CMD_HOLD;
        cmd.pick  = pick_reg;
        cmd.split = split;
        cmd.req   = req_reg;
        cmd.owner = owner_reg;
        cmd.cap   = cap_reg;
        cmd.count = count_reg;
        case (state_reg)
            fac_pkg::ST_BOOT:
                cmd.op = fac_pkg::CMD_INIT;
            fac_pkg::ST_COMMIT:
            begin
                if (found_reg && !(split && table_full))
                    cmd.op = fac_pkg::CMD_ALLOC;
            end
            fac_pkg::ST_RELEASE:
            begin
                if (|match_vec)
                    cmd.op = fac_pkg::CMD_RELEASE;
            end
            fac_pkg::ST_MERGE:
            begin
                if (pair_any)
                begin
                    cmd.op   = fac_pkg::CMD_MERGE;
                    cmd.pick = pair_idx;
                end
            end
            default:
                cmd.op = fac_pkg::CMD_HOLD;
        endcase
        // capacity write reloads the table
        if (cfg_wr && (cfg_idx == fac_pkg::REG_CAPACITY))
        begin
            cmd.op  = fac_pkg::CMD_INIT;
            cmd.cap = cap_wr;
        end
    end

    // datapath registers
    always_comb
    begin
        cnt_next        = cnt_reg;
        pick_next       = pick_reg;
        best_next       = best_reg;
        found_next      = found_reg;
        req_next        = req_reg;
        owner_next      = owner_reg;
        count_next      = count_reg;
        policy_next     = policy_reg;
        cap_next        = cap_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_size_next   = res_size_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_off_next      = m_off_reg;
        m_size_next     = m_size_reg;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            fac_pkg::ST_BOOT:
                count_next = fac_pkg::CNT_W'(1);
            fac_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next        = in_req;
                    owner_next      = in_owner;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    res_status_next = fac_pkg::STAT_OOM;
                    res_off_next    = '0;
                    res_size_next   = '0;
                end
            end
            fac_pkg::ST_SCAN:
            begin
                if (fit_vec[sel] && (!found_reg || (left_vec[sel] < best_reg)))
                begin
                    if (!(found_reg && !policy_reg))
                    begin
                        pick_next  = sel;
                        best_next  = left_vec[sel];
                        found_next = 1'b1;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
            end
            fac_pkg::ST_COMMIT:
            begin
                if (found_reg)
                begin
                    if (split && table_full)
                        res_status_next = fac_pkg::STAT_FULL;
                    else
                    begin
                        res_status_next = fac_pkg::STAT_ALLOC;
                        res_off_next    = entries[pick_reg].offset;
                        res_size_next   = req_reg;
                        if (split)
                            count_next = count_reg + 1'b1;
                    end
                end
            end
            fac_pkg::ST_RELEASE:
            begin
                if (!(|match_vec))
                    res_status_next = fac_pkg::STAT_NOOWN;
            end
            fac_pkg::ST_MERGE:
            begin
                if (pair_any)
                    count_next = count_reg - 1'b1;
                else
                    res_status_next = fac_pkg::STAT_REL;
            end
            fac_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_off_next    = res_off_reg;
                    m_size_next   = res_size_reg;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase

        // register writes
        if (cfg_wr)
        begin
            if (cfg_idx == fac_pkg::REG_CAPACITY)
            begin
                cap_next   = cap_wr;
                count_next = fac_pkg::CNT_W'(1);
            end
            else
                policy_next = cfg_wdata[0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fac_pkg::ST_BOOT;
            count_reg   <= fac_pkg::CNT_W'(1);
            policy_reg  <= 1'b1;
            cap_reg     <= fac_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            policy_reg  <= policy_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pick_reg       <= pick_next;
        best_reg       <= best_next;
        req_reg        <= req_next;
        owner_reg      <= owner_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_size_reg   <= res_size_next;
        m_status_reg   <= m_status_next;
        m_off_reg      <= m_off_next;
        m_size_reg     <= m_size_next;
    end

endmodule

### rtl/fit_allocator_with_coalescing_core.sv
// Fit allocator with coalescing: top level joining the sequencer and the row of table cells.
// Depends on fac_pkg, fac_cell and fac_ctrl.
//
// Each request is taken only while the sequencer is idle. An allocate walks the
// table one entry per cycle over the current block count (first fit stops at the
// first block that fits; a zero-byte request skips the walk). A release that
// matches no block goes straight to its result; else the merge state then merges
// neighboring free blocks pair by pair until no free pair is left. A request can
// also wait for the output register to empty before it finishes. Splits, frees
// and merges are applied by all cells at once, each cell taking its neighbor's
// entry where the table shifts. After reset the table is loaded in the boot
// state; writing total_capacity reloads it at once. A finished result waits in
// the output register while the next request is worked on.
module fit_allocator_with_coalescing_core
(
    input  logic        clk,
    input  logic        rst_n,
    // request: tdata = request_size[16:0], owner_id[24:17]; tuser = action
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    // result: tdata = block_offset[15:0], block_size[32:16]; tuser = status
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fac_pkg::cell_cmd_t                  cmd;
    fac_pkg::entry_t                     entries  [fac_pkg::MAX_BLOCKS];
    logic [fac_pkg::SIZE_W-1:0]          left_vec [fac_pkg::MAX_BLOCKS];
    logic [fac_pkg::MAX_BLOCKS-1:0]      fit_vec;
    logic [fac_pkg::MAX_BLOCKS-1:0]      match_vec;
    logic [fac_pkg::OFF_W-1:0]           out_offset;
    logic [fac_pkg::SIZE_W-1:0]          out_size;
    logic                                cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign m_tdata = {7'd0, out_size, out_offset};

    fac_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_req     (s_tdata[16:0]),
        .in_owner   (fac_pkg::OWNER_BITS'(s_tdata[24:17])),
        .in_action  (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (m_tuser),
        .out_offset (out_offset),
        .out_size   (out_size),
        .cfg_wr     (cfg_wr),
        .cfg_idx    (paddr[2]),
        .cfg_wdata  (pwdata),
        .cfg_rdata  (prdata),
        .cmd        (cmd),
        .entries    (entries),
        .fit_vec    (fit_vec),
        .left_vec   (left_vec),
        .match_vec  (match_vec)
    );

    // row of table cells
    for (genvar i = 0; i < fac_pkg::MAX_BLOCKS; i++)
    begin : g_cell
        fac_pkg::entry_t left_in;
        fac_pkg::entry_t right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_l
            assign left_in = entries[i - 1];
        end

        if (i == fac_pkg::MAX_BLOCKS - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = entries[i + 1];
        end

        fac_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .idx         (fac_pkg::IDX_W'(i)),
            .cmd         (cmd),
            .left_entry  (left_in),
            .right_entry (right_in),
            .entry       (entries[i]),
            .fit         (fit_vec[i]),
            .leftover    (left_vec[i]),
            .match       (match_vec[i])
        );
    end

endmodule

### bench/fit_allocator_with_coalescing_core_test.sv
// Testbench for the fit allocator with coalescing: directed table plus random
// allocate/release traffic, checked against a behavioral table model.
// Depends on fac_pkg and fit_allocator_with_coalescing_core.
`timescale 1ns / 100ps

module fit_allocator_with_coalescing_core_test;

    typedef struct {
        logic              action;
        logic [16:0]       size;
        logic [7:0]        owner;
        logic              known;
        fac_pkg::status_t  stat;
        logic [15:0]       offs;
        logic [16:0]       bsize;
    } row_t;

    typedef struct packed {
        fac_pkg::status_t  stat;
        logic [15:0]       offs;
        logic [16:0]       bsize;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fit_allocator_with_coalescing_core dut (.*);

    always #4 clk = ~clk;

    // Allocator table copy
    logic [15:0] blk_off [fac_pkg::MAX_BLOCKS+1];
    logic [16:0] blk_size [fac_pkg::MAX_BLOCKS+1];
    logic        blk_free [fac_pkg::MAX_BLOCKS+1];
    logic [7:0]  blk_owner [fac_pkg::MAX_BLOCKS+1];
    int          blk_count;
    logic [16:0] cap_now;
    logic        best_fit;

    result_t     pending_results [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          no_idle = 0;
    bit          hold_off = 0;

    function void table_load();
        for (int i = 0; i <= fac_pkg::MAX_BLOCKS; i++)
        begin
            blk_off[i] = '0; blk_size[i] = '0; blk_free[i] = 0; blk_owner[i] = '0;
        end
        blk_size[0] = cap_now;
        blk_free[0] = 1;
        blk_count = 1;
    endfunction

    function result_t predict_request(logic act, logic [16:0] req, logic [7:0] own);
        result_t r;
        int pick;
        int best;
        int i;
        logic [16:0] orig;
        bit hit;
        r = '{fac_pkg::STAT_OOM, 16'd0, 17'd0};
        if (act == fac_pkg::ACT_ALLOC)
        begin
            pick = -1; best = 0;
            if (req == 0) return r;
            for (i = 0; i < blk_count; i++)
                if (blk_free[i] && blk_size[i] >= req)
                begin
                    if (!best_fit) begin pick = i; break; end
                    if (pick < 0 || int'(blk_size[i] - req) < best)
                    begin
                        best = int'(blk_size[i] - req); pick = i;
                    end
                end
            if (pick < 0) return r;
            orig = blk_size[pick];
            if (orig > req && blk_count >= fac_pkg::MAX_BLOCKS)
            begin
                r.stat = fac_pkg::STAT_FULL; return r;
            end
            blk_free[pick] = 0; blk_size[pick] = req; blk_owner[pick] = own;
            if (orig > req)
            begin
                for (i = blk_count; i > pick + 1; i--)
                begin
                    blk_off[i] = blk_off[i-1]; blk_size[i] = blk_size[i-1];
                    blk_free[i] = blk_free[i-1]; blk_owner[i] = blk_owner[i-1];
                end
                blk_off[pick+1] = blk_off[pick] + req[15:0];
                blk_size[pick+1] = orig - req;
                blk_free[pick+1] = 1; blk_owner[pick+1] = '0;
                blk_count++;
            end
            r = '{fac_pkg::STAT_ALLOC, blk_off[pick], req};
        end
        else
        begin
            hit = 0;
            for (i = 0; i < blk_count; i++)
                if (blk_owner[i] == own)
                begin
                    blk_free[i] = 1; blk_owner[i] = '0; hit = 1;
                end
            if (!hit)
            begin
                r.stat = fac_pkg::STAT_NOOWN; return r;
            end
            // coalesce neighboring free blocks
            i = 0;
            while (i + 1 < blk_count)
            begin
                if (blk_free[i] && blk_free[i+1])
                begin
                    blk_size[i] += blk_size[i+1];
                    for (int k = i + 1; k + 1 < blk_count; k++)
                    begin
                        blk_off[k] = blk_off[k+1]; blk_size[k] = blk_size[k+1];
                        blk_free[k] = blk_free[k+1]; blk_owner[k] = blk_owner[k+1];
                    end
                    blk_count--;
                    blk_off[blk_count] = '0; blk_size[blk_count] = '0;
                    blk_free[blk_count] = 0; blk_owner[blk_count] = '0;
                end
                else
                    i++;
            end
            r.stat = fac_pkg::STAT_REL;
        end
        return r;
    endfunction

    // Register write over the config port, block idle
    task automatic reg_write(logic addr_sel, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {addr_sel, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr_sel == fac_pkg::REG_CAPACITY)
        begin
            cap_now = (value[16:0] > fac_pkg::CAP_MAX) ? fac_pkg::CAP_MAX : value[16:0];
            table_load();
        end
        else
            best_fit = value[0];
    endtask

    // Offer one request; tvalid stays up into the next request when no gap is taken
    task automatic send_request(logic act, logic [16:0] req, logic [7:0] own,
                                bit known, result_t typed);
        result_t p;
        if (!no_idle)
            while ($urandom_range(99) < 38)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        p = predict_request(act, req, own);
        if (known && p !== typed)
        begin
            $error("table row disagrees: status exp %0d got %0d", typed.stat, p.stat);
            fail_count++;
        end
        pending_results.insert(pending_results.size(), p);
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, own, req};
        s_tuser <= act;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4 * fac_pkg::MAX_BLOCKS) @(posedge clk);
    endtask

    // Receiver: random stalls, one long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 38);
    end

    // Result check
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result status %0d", m_tuser);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_tuser !== exp_r.stat)
                begin
                    $error("status exp %0d got %0d", exp_r.stat, m_tuser);
                    fail_count++;
                end
                if (m_tdata[15:0] !== exp_r.offs)
                begin
                    $error("block_offset exp %0d got %0d", exp_r.offs, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[32:16] !== exp_r.bsize)
                begin
                    $error("block_size exp %0d got %0d", exp_r.bsize, m_tdata[32:16]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        row_t rows [$];
        logic [16:0] rsz;
        logic [7:0]  rown;
        logic        ract;
        int pick;
        cap_now = fac_pkg::CAP_RESET;
        best_fit = 1'b1;
        table_load();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed: reset table, extremes, zero request, no owner, owner zero
        rows = '{
            '{fac_pkg::ACT_RELEASE, 17'd0, 8'd9, 1, fac_pkg::STAT_NOOWN, 16'd0, 17'd0},
            '{fac_pkg::ACT_ALLOC, 17'd0, 8'd1, 1, fac_pkg::STAT_OOM, 16'd0, 17'd0},
            '{fac_pkg::ACT_ALLOC, 17'd1025, 8'd1, 1, fac_pkg::STAT_OOM, 16'd0, 17'd0},
            '{fac_pkg::ACT_ALLOC, 17'd100, 8'd1, 1, fac_pkg::STAT_ALLOC, 16'd0, 17'd100},
            '{fac_pkg::ACT_ALLOC, 17'd200, 8'd255, 1, fac_pkg::STAT_ALLOC, 16'd100, 17'd200},
            '{fac_pkg::ACT_ALLOC, 17'd50, 8'd0, 1, fac_pkg::STAT_ALLOC, 16'd300, 17'd50},
            '{fac_pkg::ACT_RELEASE, 17'h1FFFF, 8'd1, 1, fac_pkg::STAT_REL, 16'd0, 17'd0},
            '{fac_pkg::ACT_ALLOC, 17'd60, 8'd2, 0, fac_pkg::STAT_ALLOC, 16'd0, 17'd0},
            '{fac_pkg::ACT_RELEASE, 17'd0, 8'd0, 0, fac_pkg::STAT_REL, 16'd0, 17'd0},
            '{fac_pkg::ACT_RELEASE, 17'd0, 8'd255, 0, fac_pkg::STAT_REL, 16'd0, 17'd0},
            '{fac_pkg::ACT_RELEASE, 17'd0, 8'd2, 0, fac_pkg::STAT_REL, 16'd0, 17'd0}
        };
        foreach (rows[i])
            send_request(rows[i].action, rows[i].size, rows[i].owner, rows[i].known,
                         '{rows[i].stat, rows[i].offs, rows[i].bsize});
        drain();

        // Table full: tiny capacity fragments, then split request
        reg_write(fac_pkg::REG_POLICY, 32'd0);
        reg_write(fac_pkg::REG_CAPACITY, 32'd40);
        for (int i = 0; i < 17; i++)
            send_request(fac_pkg::ACT_ALLOC, 17'd1, 8'(i % 3 + 1), 0,
                         '{fac_pkg::STAT_OOM, 16'd0, 17'd0});
        send_request(fac_pkg::ACT_RELEASE, 17'd0, 8'd2, 0,
                     '{fac_pkg::STAT_OOM, 16'd0, 17'd0});
        drain();
        reg_write(fac_pkg::REG_CAPACITY, 32'd0);
        send_request(fac_pkg::ACT_ALLOC, 17'd1, 8'd1, 1,
                     '{fac_pkg::STAT_OOM, 16'd0, 17'd0});
        drain();
        reg_write(fac_pkg::REG_CAPACITY, 32'h1FFFF);
        send_request(fac_pkg::ACT_ALLOC, 17'h10000, 8'd7, 1,
                     '{fac_pkg::STAT_ALLOC, 16'd0, 17'h10000});
        send_request(fac_pkg::ACT_ALLOC, 17'h1FFFF, 8'd7, 1,
                     '{fac_pkg::STAT_OOM, 16'd0, 17'd0});
        drain();

        // Random phases with changing capacity and policy
        for (int ph = 0; ph < 8; ph++)
        begin
            reg_write(fac_pkg::REG_POLICY, $urandom_range(1));
            case (ph % 4)
                0: reg_write(fac_pkg::REG_CAPACITY, 32'd1);
                1: reg_write(fac_pkg::REG_CAPACITY, 32'h10000);
                2: reg_write(fac_pkg::REG_CAPACITY, $urandom_range(2000, 64));
                default: reg_write(fac_pkg::REG_CAPACITY, $urandom);
            endcase
            no_idle = (ph == 2);
            if (ph == 5)
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            for (int n = 0; n < 250; n++)
            begin
                pick = $urandom_range(99);
                ract = (pick < 30) ? fac_pkg::ACT_RELEASE : fac_pkg::ACT_ALLOC;
                rown = (pick < 3) ? 8'd0 : 8'($urandom_range(8, 1));
                if (pick == 99) rown = 8'($urandom);
                if (pick > 93)
                    rsz = 17'($urandom);
                else
                    rsz = 17'($urandom_range(cap_now / 6 + 1, 0));
                send_request(ract, rsz, rown, 0, '{fac_pkg::STAT_OOM, 16'd0, 17'd0});
            end
            drain();
        end
        no_idle = 0;

        if (fail_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
